@@ rtl/mpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types, codes and sizes for the max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int ID_W          = 16;
  localparam int DEMAND_W      = 32;
  localparam int OCC_W         = 7;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } command_t;

  typedef struct packed {
    logic [ID_W-1:0]            id;
    logic signed [DEMAND_W-1:0] demand;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t item;
  } cell_ctrl_t;

endpackage

@@ rtl/mpq_if.sv @@
// ----------------------------------------------------------------------------
// mpq_cmd_if / mpq_res_if
// Valid/ready channels for queue commands and queue results.
// ----------------------------------------------------------------------------
interface mpq_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [mpq_pkg::ID_W-1:0]             request_id;
  logic signed [mpq_pkg::DEMAND_W-1:0]  demand;

  modport source (output valid, output command, output request_id, output demand,
                  input ready);
  modport sink   (input valid, input command, input request_id, input demand,
                  output ready);
endinterface

interface mpq_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic [mpq_pkg::ID_W-1:0]             served_id;
  logic signed [mpq_pkg::DEMAND_W-1:0]  served_demand;
  logic [mpq_pkg::OCC_W-1:0]            occupancy;

  modport source (output valid, output status, output served_id, output served_demand,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input served_id, input served_demand,
                  input occupancy, output ready);
endinterface

@@ rtl/max_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// max_priority_queue_core
// Bounded max-priority queue held as a sorted chain of cells.
//
// channel  dir  fields
// cmd      in   command, request_id, demand
// res      out  status, served_id, served_demand, occupancy
//
// One command per cycle while no result is stalled; the result is registered in the cycle after the beat.
// Every cell compares its entry with the pushed demand in the same cycle,
// then keeps, takes the new item or shifts in from a neighbour.
// Reset clears the fill count and the result valid flag; entries need none.
// A stalled result holds and blocks cmd until it is taken.
// ----------------------------------------------------------------------------
module max_priority_queue_core #(
  parameter int QUEUE_DEPTH = mpq_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  mpq_cmd_if.sink         cmd,
  mpq_res_if.source       res
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  mpq_pkg::cell_ctrl_t ctrl;
  mpq_pkg::entry_t     entries [QUEUE_DEPTH];
  logic                ge      [QUEUE_DEPTH];
  logic                accept;
  logic                full;
  logic                empty;
  mpq_pkg::status_t    status_next;

  assign cmd.ready = !rst && (!res.valid || res.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    ctrl.item.id     = cmd.request_id;
    ctrl.item.demand = cmd.demand;
    ctrl.push        = accept && (cmd.command == mpq_pkg::CMD_PUSH) && !full;
    ctrl.pop         = accept && (cmd.command == mpq_pkg::CMD_POP) && !empty;
    count_next       = count;
    if (ctrl.push) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count - 1'b1;
    end
    if (cmd.command == mpq_pkg::CMD_PUSH) begin
      status_next = full ? mpq_pkg::ST_FULL : mpq_pkg::ST_PUSHED;
    end else begin
      status_next = empty ? mpq_pkg::ST_EMPTY : mpq_pkg::ST_POPPED;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            occ;
    logic            lge;
    mpq_pkg::entry_t lent;
    mpq_pkg::entry_t rent;

    assign occ = (count > CNT_W'(i));
    if (i == 0) begin : g_first
      assign lge  = 1'b0;
      assign lent = ctrl.item;
    end else begin : g_mid
      assign lge  = ge[i-1];
      assign lent = entries[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rent = entries[i];
    end else begin : g_inner
      assign rent = entries[i+1];
    end

    mpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ),
      .left_ge     (lge),
      .left_entry  (lent),
      .right_entry (rent),
      .ge          (ge[i]),
      .entry       (entries[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.status    <= status_next;
      res.occupancy <= mpq_pkg::OCC_W'(count_next);
      if (ctrl.pop) begin
        res.served_id     <= entries[0].id;
        res.served_demand <= entries[0].demand;
      end else begin
        res.served_id     <= '0;
        res.served_demand <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond depth");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res.valid)
    else $error("accepted beat without result");

  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> (res.served_demand == $past(entries[0].demand)) &&
                 (res.served_id == $past(entries[0].id)))
    else $error("popped entry is not the head");

  a_served_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && !ctrl.pop) |=> (res.served_id == '0) && (res.served_demand == '0))
    else $error("served fields set without pop");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("fill count moved without a beat");

endmodule

@@ rtl/mpq_cell.sv @@
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: keeps, takes the new item or shifts.
// ----------------------------------------------------------------------------
module mpq_cell (
  input  logic                clk,
  input  mpq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                left_ge,
  input  mpq_pkg::entry_t     left_entry,
  input  mpq_pkg::entry_t     right_entry,
  output logic                ge,
  output mpq_pkg::entry_t     entry
);

  assign ge = occupied && (entry.demand >= ctrl.item.demand);

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      entry <= right_entry;
    end else if (ctrl.push && !ge) begin
      entry <= left_ge ? ctrl.item : left_entry;
    end
  end

endmodule
